@@ hw/rtl/ddcf_pkg.sv @@
// Shared types and constants for the dual DAC command framer.
// Holds request and status codes, frame command bytes and the clamp function.
// No dependencies.
package ddcf_pkg;

    localparam int CodeW = 16;

    typedef enum logic [2:0] {
        ACT_INIT       = 3'd0,
        ACT_WRITE_ONE  = 3'd1,
        ACT_WRITE_BOTH = 3'd2,
        ACT_FAULT      = 3'd3,
        ACT_READ       = 3'd4,
        ACT_SET_MODE   = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_PARAM  = 3'd1,
        ST_NOINIT = 3'd2,
        ST_RANGE  = 3'd3,
        ST_UNSUP  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_FAULT_CODE = 2'd0,
        REG_CODE_MIN   = 2'd1,
        REG_CODE_MAX   = 2'd2
    } reg_index_t;

    localparam logic [7:0] CMD_WRITE_A  = 8'h18;
    localparam logic [7:0] CMD_WRITE_B  = 8'h19;
    localparam logic [7:0] CMD_POWER_UP = 8'h20;
    localparam logic [7:0] CMD_RESET    = 8'h28;
    localparam logic [7:0] CMD_LDAC     = 8'h30;
    localparam logic [7:0] CMD_REF_GAIN = 8'h38;

    localparam logic [CodeW-1:0] DATA_RESET    = 16'h0001;
    localparam logic [CodeW-1:0] DATA_REF_GAIN = 16'h0001;
    localparam logic [CodeW-1:0] DATA_LDAC_IGN = 16'h0003;
    localparam logic [CodeW-1:0] DATA_PWR_BOTH = 16'h0003;

    localparam logic [CodeW-1:0] FAULT_CODE_RST = 16'd3932;
    localparam logic [CodeW-1:0] CODE_MIN_RST   = 16'd5243;
    localparam logic [CodeW-1:0] CODE_MAX_RST   = 16'd60293;

    // Init sequence beat numbers
    localparam logic [2:0] BEAT_RESET    = 3'd0;
    localparam logic [2:0] BEAT_REF_GAIN = 3'd1;
    localparam logic [2:0] BEAT_LDAC     = 3'd2;
    localparam logic [2:0] BEAT_WRITE_A  = 3'd3;
    localparam logic [2:0] BEAT_WRITE_B  = 3'd4;
    localparam logic [2:0] BEAT_PWR_UP   = 3'd5;

    // Fault code is exempt; otherwise the low bound wins over the high bound
    function automatic logic [CodeW-1:0] clamp_code(
        input logic [CodeW-1:0] code,
        input logic [CodeW-1:0] fault,
        input logic [CodeW-1:0] lo,
        input logic [CodeW-1:0] hi
    );
        logic [CodeW-1:0] res;
        if (code == fault)
            res = code;
        else if (code < lo)
            res = lo;
        else if (code > hi)
            res = hi;
        else
            res = code;
        return res;
    endfunction

endpackage

@@ hw/rtl/dual_dac_command_framer_core.sv @@
// Dual DAC command framer: requests in, 24-bit command frames and status out.
// Depends on ddcf_pkg.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser action, s_tdata request fields
//  m_      | out | m_tvalid/m_tready  | m_tuser frame_valid, m_tdata frame, m_tlast
//  cfg_    | in  | cfg_we (no wait)   | cfg_index, cfg_data
//
// A request is latched into the request stage, then gives one result per cycle
// into the output register unless low m_tready holds the output, then the stage:
// one for most requests, write A then B for write both and fault level when
// ready, the init beats for init. A new request is taken in the cycle its
// predecessor emits its final result. Reset clears both stages, ready, the
// stored codes and loads the register defaults.
module dual_dac_command_framer_core
    import ddcf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [2:0]  s_tuser,   // action
    input  logic [39:0] s_tdata,   // axis[1:0], first_code[17:2], second_code[33:18],
                                   // want_voltage[34], zero[39:35]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        m_tuser,   // frame_valid
    output logic [47:0] m_tdata,   // frame_command[7:0], frame_data[23:8], status[26:24],
                                   // read_code[42:27], zero[47:43]
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration
    logic [CodeW-1:0] fault_code_reg, code_min_reg, code_max_reg;

    // device state
    logic             ready_reg;
    logic [CodeW-1:0] code_a_reg, code_b_reg;

    // request stage
    logic             stg_valid_reg;
    logic [2:0]       stg_action_reg;
    logic [1:0]       stg_axis_reg;
    logic [CodeW-1:0] stg_first_reg, stg_second_reg;
    logic             stg_want_v_reg;
    logic [2:0]       beat_reg, beat_next;

    // output register
    logic             out_valid_reg;
    logic             out_frame_reg;
    logic [7:0]       out_cmd_reg;
    logic [CodeW-1:0] out_data_reg, out_read_reg;
    logic [2:0]       out_status_reg;
    logic             out_last_reg;

    // current beat
    logic             r_frame;
    logic [7:0]       r_cmd;
    logic [CodeW-1:0] r_data, r_read;
    status_t          r_status;
    logic             r_last;
    logic [CodeW-1:0] k_first, k_second;
    logic             out_free, emit, take;

    assign k_first  = clamp_code(stg_first_reg, fault_code_reg, code_min_reg, code_max_reg);
    assign k_second = clamp_code(stg_second_reg, fault_code_reg, code_min_reg, code_max_reg);

    always_comb
    begin
        r_frame  = 1'b0;
        r_cmd    = 8'h00;
        r_data   = '0;
        r_read   = '0;
        r_status = ST_OK;
        r_last   = 1'b1;
        case (stg_action_reg)
            ACT_INIT:
            begin
                r_frame = 1'b1;
                r_last  = (beat_reg == BEAT_PWR_UP);
                case (beat_reg)
                    BEAT_RESET:
                    begin
                        r_cmd  = CMD_RESET;
                        r_data = DATA_RESET;
                    end
                    BEAT_REF_GAIN:
                    begin
                        r_cmd  = CMD_REF_GAIN;
                        r_data = DATA_REF_GAIN;
                    end
                    BEAT_LDAC:
                    begin
                        r_cmd  = CMD_LDAC;
                        r_data = DATA_LDAC_IGN;
                    end
                    BEAT_WRITE_A:
                    begin
                        r_cmd  = CMD_WRITE_A;
                        r_data = fault_code_reg;
                    end
                    BEAT_WRITE_B:
                    begin
                        r_cmd  = CMD_WRITE_B;
                        r_data = fault_code_reg;
                    end
                    default:
                    begin
                        r_cmd  = CMD_POWER_UP;
                        r_data = DATA_PWR_BOTH;
                    end
                endcase
            end
            ACT_WRITE_ONE:
            begin
                if (stg_axis_reg[1])
                    r_status = ST_PARAM;
                else if (!ready_reg)
                    r_status = ST_NOINIT;
                else
                begin
                    r_frame  = 1'b1;
                    r_cmd    = stg_axis_reg[0] ? CMD_WRITE_B : CMD_WRITE_A;
                    r_data   = k_first;
                    r_status = (k_first == stg_first_reg) ? ST_OK : ST_RANGE;
                end
            end
            ACT_WRITE_BOTH:
            begin
                if (!ready_reg)
                    r_status = ST_NOINIT;
                else
                begin
                    r_frame = 1'b1;
                    r_last  = beat_reg[0];
                    if (!beat_reg[0])
                    begin
                        r_cmd  = CMD_WRITE_A;
                        r_data = k_first;
                    end
                    else
                    begin
                        r_cmd    = CMD_WRITE_B;
                        r_data   = k_second;
                        r_status = (k_first == stg_first_reg && k_second == stg_second_reg)
                                   ? ST_OK : ST_RANGE;
                    end
                end
            end
            ACT_FAULT:
            begin
                if (!ready_reg)
                    r_status = ST_NOINIT;
                else
                begin
                    r_frame = 1'b1;
                    r_last  = beat_reg[0];
                    r_cmd   = beat_reg[0] ? CMD_WRITE_B : CMD_WRITE_A;
                    r_data  = fault_code_reg;
                end
            end
            ACT_READ:
            begin
                if (!stg_axis_reg[1])
                    r_read = stg_axis_reg[0] ? code_b_reg : code_a_reg;
            end
            ACT_SET_MODE:
            begin
                if (!ready_reg)
                    r_status = ST_NOINIT;
                else if (!stg_want_v_reg)
                    r_status = ST_UNSUP;
            end
            default:
                r_status = ST_PARAM;
        endcase
    end

    assign out_free  = !out_valid_reg || m_tready;
    assign emit      = stg_valid_reg && out_free;
    assign s_tready  = !stg_valid_reg || (emit && r_last);
    assign take      = s_tvalid && s_tready;
    assign beat_next = (emit && !r_last) ? beat_reg + 3'd1 : beat_reg;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_code_reg <= FAULT_CODE_RST;
            code_min_reg   <= CODE_MIN_RST;
            code_max_reg   <= CODE_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FAULT_CODE: fault_code_reg <= cfg_data;
                REG_CODE_MIN:   code_min_reg   <= cfg_data;
                REG_CODE_MAX:   code_max_reg   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // device state follows the results as they leave the stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg  <= 1'b0;
            code_a_reg <= '0;
            code_b_reg <= '0;
        end
        else if (emit && r_last && r_frame)
        begin
            case (stg_action_reg)
                ACT_INIT:
                begin
                    ready_reg  <= 1'b1;
                    code_a_reg <= fault_code_reg;
                    code_b_reg <= fault_code_reg;
                end
                ACT_WRITE_ONE:
                begin
                    if (stg_axis_reg[0])
                        code_b_reg <= k_first;
                    else
                        code_a_reg <= k_first;
                end
                ACT_WRITE_BOTH:
                begin
                    code_a_reg <= k_first;
                    code_b_reg <= k_second;
                end
                ACT_FAULT:
                begin
                    code_a_reg <= fault_code_reg;
                    code_b_reg <= fault_code_reg;
                end
                default: ;
            endcase
        end
    end

    // request stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            beat_reg      <= 3'd0;
        end
        else if (take)
        begin
            stg_valid_reg <= 1'b1;
            beat_reg      <= 3'd0;
        end
        else
        begin
            if (emit && r_last)
                stg_valid_reg <= 1'b0;
            beat_reg <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stg_action_reg <= s_tuser;
            stg_axis_reg   <= s_tdata[1:0];
            stg_first_reg  <= s_tdata[17:2];
            stg_second_reg <= s_tdata[33:18];
            stg_want_v_reg <= s_tdata[34];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= stg_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_frame_reg  <= r_frame;
            out_cmd_reg    <= r_cmd;
            out_data_reg   <= r_data;
            out_status_reg <= r_status;
            out_read_reg   <= r_read;
            out_last_reg   <= r_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_frame_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_read_reg, out_status_reg, out_data_reg, out_cmd_reg};

    // checks
    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg |-> (beat_reg <= BEAT_PWR_UP))
        else $error("beat counter past end of init sequence");

    a_init_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && r_last && stg_action_reg == ACT_INIT)
        |=> (ready_reg && code_a_reg == code_b_reg))
        else $error("init did not leave block ready with matching codes");

    a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tuser && m_tdata[26:24] == ST_OK))
        else $error("non-final result without frame or with status");

    a_single_take: assert property (@(posedge clk) disable iff (!rst_n)
        (take && stg_valid_reg) |-> (emit && r_last))
        else $error("request taken while stage still busy");

endmodule
